@@ rtl/ws2812_pixel_strip_driver_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ws2812 strip driver assertion macros
// Shared concurrent assertion forms for the strip driver checker.
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_STRIP_DRIVER_UNIT_DEFINES_SVH
`define WS2812_PIXEL_STRIP_DRIVER_UNIT_DEFINES_SVH

// assertion on a given clock and active-low reset
`define WSDRV_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("strip driver assertion failed");

// assertion on the block clock and reset
`define WSDRV_ASSERT(lbl, prop) \
  `WSDRV_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/wsdrv_pkg.sv @@
// ----------------------------------------------------------------------------
// wsdrv_pkg
// Types, request codes, register indexes and sizes of the strip driver.
// ----------------------------------------------------------------------------
package wsdrv_pkg;

  // store size
  localparam int MAX_LEDS     = 256;
  localparam int LED_AW       = $clog2(MAX_LEDS);
  localparam int LED_CNT_W    = $clog2(MAX_LEDS + 1);
  localparam int BITS_PER_LED = 24;
  localparam int BIT_POS_W    = $clog2(BITS_PER_LED);

  // register widths
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 16;
  localparam int PERIOD_W     = 12;
  localparam int TICK_W       = 16;

  typedef logic [BITS_PER_LED-1:0] color_t;

  // request codes
  localparam logic [2:0] REQ_TICK          = 3'd0;
  localparam logic [2:0] REQ_WRITE         = 3'd1;
  localparam logic [2:0] REQ_REFRESH       = 3'd2;
  localparam logic [2:0] REQ_CLEAR_REFRESH = 3'd3;
  localparam logic [2:0] REQ_WRITE_REFRESH = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_ACTIVE_LEDS = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BIT_PERIOD  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_ONE_HIGH    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ZERO_HIGH   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_LATCH       = 3'd4;

  // register reset values
  localparam logic [LED_CNT_W-1:0] RST_ACTIVE_LEDS = LED_CNT_W'(8);
  localparam logic [PERIOD_W-1:0]  RST_BIT_PERIOD  = PERIOD_W'(80);
  localparam logic [PERIOD_W-1:0]  RST_ONE_HIGH    = PERIOD_W'(51);
  localparam logic [PERIOD_W-1:0]  RST_ZERO_HIGH   = PERIOD_W'(26);
  localparam logic [TICK_W-1:0]    RST_LATCH       = TICK_W'(3200);

  // write request into the pixel store
  typedef struct packed {
    logic              we;
    logic              clr;
    logic [LED_AW-1:0] addr;
    color_t            data;
  } store_wr_t;

endpackage

@@ rtl/ws2812_pixel_strip_driver_unit.sv @@
// ----------------------------------------------------------------------------
// ws2812_pixel_strip_driver_unit
// WS2812 strip driver: pixel store, one-wire bit sequencer and latch timer.
// ----------------------------------------------------------------------------
// Each request is one waveform tick. A request is taken whenever start is high
// (busy stays low), one per clock, and its result appears on done_o with
// line_level_o, sending_o and request_rejected_o once it has passed the request
// register and the result register, held for exactly one cycle; the receiver
// cannot stall, so results must be sampled on the strobe. The sustained rate
// is one request per clock, set by the combinational bit sequencer update
// between the request register and the result register. The pixel store needs
// no clearing pass: per-entry valid bits clear at reset and by a clear request.
module ws2812_pixel_strip_driver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     req_type_i,
  input  logic [7:0]                     pixel_index_i,
  input  logic [7:0]                     red_level_i,
  input  logic [7:0]                     green_level_i,
  input  logic [7:0]                     blue_level_i,
  input  logic                           cfg_we_i,
  input  logic [wsdrv_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [wsdrv_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output logic                           done_o,
  output logic                           line_level_o,
  output logic                           sending_o,
  output logic                           request_rejected_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BITS,
    PH_LATCH
  } phase_e;

  // configuration registers
  logic [wsdrv_pkg::LED_CNT_W-1:0] active_q;
  logic [wsdrv_pkg::PERIOD_W-1:0]  period_q;
  logic [wsdrv_pkg::PERIOD_W-1:0]  one_high_q;
  logic [wsdrv_pkg::PERIOD_W-1:0]  zero_high_q;
  logic [wsdrv_pkg::TICK_W-1:0]    latch_q;

  // request register
  logic       item_vld_q;
  logic [2:0] req_q;
  logic [7:0] idx_q;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;

  // sequencer state
  phase_e                          phase_q, phase_d;
  logic [wsdrv_pkg::LED_AW-1:0]    led_q, led_d;
  logic [wsdrv_pkg::BIT_POS_W-1:0] bit_q, bit_d;
  logic [wsdrv_pkg::TICK_W-1:0]    tick_q, tick_d;
  wsdrv_pkg::color_t               shift_q, shift_d;

  // result register
  logic done_q;
  logic level_q, level_d;
  logic sending_q, sending_d;
  logic rej_q, rej_d;

  // store interface
  wsdrv_pkg::store_wr_t store_wr;
  wsdrv_pkg::color_t    next_color;
  wsdrv_pkg::color_t    head_color;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= wsdrv_pkg::RST_ACTIVE_LEDS;
      period_q    <= wsdrv_pkg::RST_BIT_PERIOD;
      one_high_q  <= wsdrv_pkg::RST_ONE_HIGH;
      zero_high_q <= wsdrv_pkg::RST_ZERO_HIGH;
      latch_q     <= wsdrv_pkg::RST_LATCH;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        wsdrv_pkg::CFG_ACTIVE_LEDS: active_q    <= cfg_wdata_i[wsdrv_pkg::LED_CNT_W-1:0];
        wsdrv_pkg::CFG_BIT_PERIOD:  period_q    <= cfg_wdata_i[wsdrv_pkg::PERIOD_W-1:0];
        wsdrv_pkg::CFG_ONE_HIGH:    one_high_q  <= cfg_wdata_i[wsdrv_pkg::PERIOD_W-1:0];
        wsdrv_pkg::CFG_ZERO_HIGH:   zero_high_q <= cfg_wdata_i[wsdrv_pkg::PERIOD_W-1:0];
        wsdrv_pkg::CFG_LATCH:       latch_q     <= cfg_wdata_i[wsdrv_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture, one per clock
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q   <= req_type_i;
      idx_q   <= pixel_index_i;
      red_q   <= red_level_i;
      green_q <= green_level_i;
      blue_q  <= blue_level_i;
    end
  end

  // one tick of the sequencer
  logic                            is_req, take_req;
  logic                            do_write, do_clear, do_start;
  wsdrv_pkg::color_t               new_color, start_color;
  logic [wsdrv_pkg::LED_CNT_W-1:0] led_cnt;
  logic [wsdrv_pkg::PERIOD_W-1:0]  period_eff, high_ticks;
  logic [wsdrv_pkg::TICK_W-1:0]    latch_eff;
  phase_e                          ph_s;
  logic [wsdrv_pkg::LED_AW-1:0]    led_s;
  logic [wsdrv_pkg::BIT_POS_W-1:0] bit_s;
  logic [wsdrv_pkg::TICK_W-1:0]    tick_s;
  wsdrv_pkg::color_t               shift_s;
  logic [wsdrv_pkg::TICK_W:0]      tick_inc;
  logic [wsdrv_pkg::BIT_POS_W-1:0] bit_inc;
  logic [wsdrv_pkg::LED_CNT_W-1:0] led_inc;

  always_comb begin
    is_req    = (req_q == wsdrv_pkg::REQ_WRITE) || (req_q == wsdrv_pkg::REQ_REFRESH) ||
                (req_q == wsdrv_pkg::REQ_CLEAR_REFRESH) ||
                (req_q == wsdrv_pkg::REQ_WRITE_REFRESH);
    take_req  = item_vld_q && is_req && (phase_q == PH_IDLE);
    do_write  = take_req && ((req_q == wsdrv_pkg::REQ_WRITE) ||
                             (req_q == wsdrv_pkg::REQ_WRITE_REFRESH));
    do_clear  = take_req && (req_q == wsdrv_pkg::REQ_CLEAR_REFRESH);
    do_start  = take_req && (req_q != wsdrv_pkg::REQ_WRITE);
    new_color = {green_q, red_q, blue_q};

    // entry zero as it stands after this tick's write or clear
    if (do_write && (idx_q == '0)) begin
      start_color = new_color;
    end else if (do_clear) begin
      start_color = '0;
    end else begin
      start_color = head_color;
    end

    led_cnt    = (active_q > wsdrv_pkg::LED_CNT_W'(wsdrv_pkg::MAX_LEDS)) ?
                 wsdrv_pkg::LED_CNT_W'(wsdrv_pkg::MAX_LEDS) : active_q;
    period_eff = (period_q == '0) ? wsdrv_pkg::PERIOD_W'(1) : period_q;
    latch_eff  = (latch_q == '0) ? wsdrv_pkg::TICK_W'(1) : latch_q;

    // state after a refresh start
    if (do_start) begin
      ph_s    = (led_cnt != '0) ? PH_BITS : PH_LATCH;
      led_s   = '0;
      bit_s   = '0;
      tick_s  = '0;
      shift_s = (led_cnt != '0) ? start_color : shift_q;
    end else begin
      ph_s    = phase_q;
      led_s   = led_q;
      bit_s   = bit_q;
      tick_s  = tick_q;
      shift_s = shift_q;
    end

    high_ticks = shift_s[wsdrv_pkg::BITS_PER_LED-1] ? one_high_q : zero_high_q;
    tick_inc   = {1'b0, tick_s} + 1'b1;
    bit_inc    = bit_s + 1'b1;
    led_inc    = {1'b0, led_s} + 1'b1;

    phase_d   = ph_s;
    led_d     = led_s;
    bit_d     = bit_s;
    tick_d    = tick_s;
    shift_d   = shift_s;
    level_d   = 1'b0;
    sending_d = 1'b0;
    rej_d     = item_vld_q && is_req && (phase_q != PH_IDLE);

    unique case (ph_s)
      PH_BITS: begin
        level_d   = tick_s < {{(wsdrv_pkg::TICK_W-wsdrv_pkg::PERIOD_W){1'b0}}, high_ticks};
        sending_d = 1'b1;
        tick_d    = tick_inc[wsdrv_pkg::TICK_W-1:0];
        if (tick_inc >= {{(wsdrv_pkg::TICK_W+1-wsdrv_pkg::PERIOD_W){1'b0}}, period_eff}) begin
          tick_d  = '0;
          shift_d = {shift_s[wsdrv_pkg::BITS_PER_LED-2:0], 1'b0};
          bit_d   = bit_inc;
          if (bit_inc >= wsdrv_pkg::BIT_POS_W'(wsdrv_pkg::BITS_PER_LED)) begin
            bit_d = '0;
            led_d = led_inc[wsdrv_pkg::LED_AW-1:0];
            if (led_inc >= led_cnt) begin
              phase_d = PH_LATCH;
            end else begin
              shift_d = next_color;
            end
          end
        end
      end
      PH_LATCH: begin
        sending_d = 1'b1;
        tick_d    = tick_inc[wsdrv_pkg::TICK_W-1:0];
        if (tick_inc >= {1'b0, latch_eff}) begin
          tick_d  = '0;
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // sequencer state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      led_q     <= '0;
      bit_q     <= '0;
      tick_q    <= '0;
      shift_q   <= '0;
      done_q    <= 1'b0;
      level_q   <= 1'b0;
      sending_q <= 1'b0;
      rej_q     <= 1'b0;
    end else begin
      done_q <= item_vld_q;
      if (item_vld_q) begin
        phase_q   <= phase_d;
        led_q     <= led_d;
        bit_q     <= bit_d;
        tick_q    <= tick_d;
        shift_q   <= shift_d;
        level_q   <= level_d;
        sending_q <= sending_d;
        rej_q     <= rej_d;
      end
    end
  end

  // store write request
  assign store_wr.we   = do_write;
  assign store_wr.clr  = do_clear;
  assign store_wr.addr = idx_q[wsdrv_pkg::LED_AW-1:0];
  assign store_wr.data = new_color;

  // prefetch of the next LED's color
  wsdrv_pixel_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (store_wr),
    .rd_addr_i (led_q + 1'b1),
    .rd_data_o (next_color),
    .head_o    (head_color)
  );

  assign done_o             = done_q;
  assign line_level_o       = level_q;
  assign sending_o          = sending_q;
  assign request_rejected_o = rej_q;

endmodule

@@ rtl/wsdrv_pixel_store.sv @@
// ----------------------------------------------------------------------------
// wsdrv_pixel_store
// Per-LED color memory with valid bits, entry zero mirror and registered read.
// ----------------------------------------------------------------------------
module wsdrv_pixel_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsdrv_pkg::store_wr_t        wr_i,
  input  logic [wsdrv_pkg::LED_AW-1:0] rd_addr_i,
  output wsdrv_pkg::color_t           rd_data_o,
  output wsdrv_pkg::color_t           head_o
);

  wsdrv_pkg::color_t mem_q [wsdrv_pkg::MAX_LEDS];
  logic [wsdrv_pkg::MAX_LEDS-1:0] valid_q;
  wsdrv_pkg::color_t rd_raw_q;
  logic              rd_vld_q;
  wsdrv_pkg::color_t head_q;

  // color memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_raw_q <= mem_q[rd_addr_i];
  end

  // valid bits, an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.clr) begin
        valid_q <= '0;
      end else if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  // mirror of entry zero for a refresh started in the same tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (wr_i.clr) begin
      head_q <= '0;
    end else if (wr_i.we && (wr_i.addr == '0)) begin
      head_q <= wr_i.data;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;
  assign head_o    = head_q;

endmodule

@@ rtl/wsdrv_checker.sv @@
// ----------------------------------------------------------------------------
// wsdrv_checker
// Port-level checks of the strip driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "ws2812_pixel_strip_driver_unit_defines.svh"

module wsdrv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic line_level_o,
  input logic sending_o,
  input logic request_rejected_o
);

  // every taken request gives a result after the request and result registers
  `WSDRV_ASSERT(a_req_gives_result, start && !busy |-> ##2 done_o)

  // no result without a request taken before it
  `WSDRV_ASSERT(a_no_stray_result, done_o |-> $past(start && !busy, 2))

  // the line stays low when nothing is being sent
  `WSDRV_ASSERT(a_idle_line_low, done_o && !sending_o |-> !line_level_o)

  // a request is only turned away during a refresh
  `WSDRV_ASSERT(a_reject_while_sending, done_o && request_rejected_o |-> sending_o)

endmodule

bind ws2812_pixel_strip_driver_unit wsdrv_checker u_wsdrv_checker (.*);
